/* hdl/cuckoo_hash_map_unit_macros.svh */
// Assertion helpers used by chm_datapath.
`ifndef CUCKOO_HASH_MAP_UNIT_MACROS_SVH
`define CUCKOO_HASH_MAP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define CHM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Checked at every edge, reset included.
`define CHM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);
`else
`define CHM_ASSERT(lbl, prop, msg)
`define CHM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/chm_pkg.sv */
package chm_pkg;

    localparam logic [63:0]  EMPTY_MARK = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [127:0] MULT_ONE   = {64'd11832546345696851205,
                                           64'd16384545419507531801};
    localparam logic [127:0] MULT_TWO   = {64'd16416102846353452488,
                                           64'd16315805464367464543};
    localparam logic [15:0]  LFSR_TAPS  = 16'hB400;

    // actions
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FAILED   = 2'd2;
    localparam logic [1:0] ST_RESERVED = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_KEY_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_MAX_KICKS   = 2'd1;
    localparam logic [1:0] CFG_CHOICE_SEED = 2'd2;

    localparam logic [1:0]  KEY_LEN_THREE   = 2'd3;
    localparam logic [1:0]  KEY_LEN_RESET   = 2'd3;
    localparam logic [15:0] MAX_KICKS_RESET = 16'd5000;
    localparam logic [15:0] SEED_RESET      = 16'd1;

    localparam int CFG_W = 16;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic hash_go;
        logic mem_rd;
        logic clr_step;
        logic commit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic hash_done;
        logic clr_last;
        logic skip;
        logic again;
        logic out_free;
    } t_dp_sts;

    // partial product order for the low 128 bits: {a word, b word}
    function automatic logic [3:0] pair_of(input logic [3:0] step);
        logic [3:0] p;
        unique case (step)
            4'd0:    p = {2'd0, 2'd0};
            4'd1:    p = {2'd0, 2'd1};
            4'd2:    p = {2'd1, 2'd0};
            4'd3:    p = {2'd0, 2'd2};
            4'd4:    p = {2'd1, 2'd1};
            4'd5:    p = {2'd2, 2'd0};
            4'd6:    p = {2'd0, 2'd3};
            4'd7:    p = {2'd1, 2'd2};
            4'd8:    p = {2'd2, 2'd1};
            4'd9:    p = {2'd3, 2'd0};
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
    endfunction

endpackage

/* hdl/chm_stream_if.sv */
interface chm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/chm_hash.sv */
// 128x128 low-half multiply by a constant, one 32x32 product per cycle,
// then remainder by a constant, four bits per cycle.
module chm_hash import chm_pkg::*; #(
    parameter int           SLOT_W = 12,
    parameter int unsigned  MOD    = 4091,
    parameter logic [127:0] MULT   = 128'd1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [127:0]      i_key,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_slot
);
    localparam logic [SLOT_W:0] MOD_V = (SLOT_W + 1)'(MOD);

    logic [127:0]      r_a, r_acc;
    logic [63:0]       r_prod;
    logic [1:0]        r_psh;
    logic [3:0]        r_cnt;
    logic [4:0]        r_mcnt;
    logic              r_mul_busy, r_pv, r_pl, r_mod_busy, r_done;
    logic [SLOT_W-1:0] r_rem, n_rem;
    logic [3:0]        pair;
    logic [31:0]       a_sel, b_sel;

    assign pair  = pair_of(r_cnt);
    assign a_sel = r_a[32*pair[3:2] +: 32];
    assign b_sel = MULT[32*pair[1:0] +: 32];

    always_comb begin
        logic [SLOT_W:0] t;
        n_rem = r_rem;
        for (int b = 0; b < 4; b++) begin
            t = {n_rem, r_acc[127 - b]};
            if (t >= MOD_V) t = t - MOD_V;
            n_rem = t[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_pv       <= 1'b0;
            r_pl       <= 1'b0;
            r_mod_busy <= 1'b0;
            r_done     <= 1'b0;
            r_cnt      <= '0;
            r_mcnt     <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mul_busy <= 1'b1;
                r_cnt      <= '0;
                r_pv       <= 1'b0;
                r_pl       <= 1'b0;
            end else if (r_mul_busy) begin
                r_cnt <= r_cnt + 4'd1;
                r_pv  <= 1'b1;
                r_pl  <= (r_cnt == 4'd9);
                if (r_cnt == 4'd9) r_mul_busy <= 1'b0;
            end else begin
                r_pv <= 1'b0;
                r_pl <= 1'b0;
            end
            if (r_pv && r_pl) begin
                r_mod_busy <= 1'b1;
                r_mcnt     <= '0;
            end else if (r_mod_busy) begin
                r_mcnt <= r_mcnt + 5'd1;
                if (r_mcnt == 5'd31) begin
                    r_mod_busy <= 1'b0;
                    r_done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_key;
            r_acc <= '0;
            r_rem <= '0;
        end else begin
            if (r_mul_busy) begin
                r_prod <= a_sel * b_sel;
                r_psh  <= pair[3:2] + pair[1:0];
            end
            if (r_pv) begin
                r_acc <= r_acc + ({64'd0, r_prod} << {r_psh, 5'd0});
            end else if (r_mod_busy) begin
                r_acc <= r_acc << 4;
                r_rem <= n_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem;
endmodule

/* hdl/chm_datapath.sv */
`include "cuckoo_hash_map_unit_macros.svh"

module chm_datapath import chm_pkg::*; #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_KEY_WORDS = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_word         i_in_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_out_word        o_out_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts
);
    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int KW    = MAX_KEY_WORDS;
    localparam int ROW_W = KW * 64 + 32;

    logic [1:0]  r_key_len;
    logic [15:0] r_max_kicks, r_lfsr, r_kicks, lfsr_nx;
    logic [1:0]  r_act, r_res_st, eval_st;
    logic [63:0] r_k0, r_k1, r_k2;
    logic [31:0] r_val, r_res_val, eval_vo;
    logic        r_out_valid;
    t_out_word   r_out;
    logic [AW-1:0] r_clr, s1, s2;
    logic [ROW_W-1:0] mem1 [TABLE_ENTRIES];
    logic [ROW_W-1:0] mem2 [TABLE_ENTRIES];
    logic [ROW_W-1:0] r_row1, r_row2, ins1_row, ins2_row, clr_row, wd1, wd2;
    logic [63:0] w2_1, w2_2, ev0, ev1, ev2;
    logic [31:0] ev_v;
    logic        words3, d1, d2, match1, match2, empty1, empty2;
    logic        wr1, wr2, again, we1, we2;
    logic [AW-1:0] wa1, wa2;
    logic [127:0] key1, key2;

    assign words3 = (r_key_len == KEY_LEN_THREE) && (KW >= 3);

    // hash key packing per table
    always_comb begin
        if (words3) begin
            key1 = {r_k0 | (r_k1 >> 14), (r_k1 << 50) | r_k2};
            key2 = {(r_k2 >> 8) | (r_k1 >> 31),
                    (r_k2 << 56) | (r_k1 << 33) | (r_k0 + r_k1)};
        end else begin
            key1 = {r_k0, r_k1};
            key2 = {r_k0, r_k1};
        end
    end

    chm_hash #(.SLOT_W(AW), .MOD(TABLE_ENTRIES - 5), .MULT(MULT_ONE)) u_hash1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.hash_go),
        .i_key(key1), .o_done(d1), .o_slot(s1)
    );
    chm_hash #(.SLOT_W(AW), .MOD(TABLE_ENTRIES - 2), .MULT(MULT_TWO)) u_hash2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.hash_go),
        .i_key(key2), .o_done(d2), .o_slot(s2)
    );

    assign clr_row = {32'd0, {KW{EMPTY_MARK}}};

    generate
        if (KW >= 3) begin : g_three
            assign w2_1     = r_row1[128 +: 64];
            assign w2_2     = r_row2[128 +: 64];
            assign ins1_row = {r_val, (words3 ? r_k2 : w2_1), r_k1, r_k0};
            assign ins2_row = {r_val, (words3 ? r_k2 : w2_2), r_k1, r_k0};
        end else begin : g_two
            assign w2_1     = '0;
            assign w2_2     = '0;
            assign ins1_row = {r_val, r_k1, r_k0};
            assign ins2_row = {r_val, r_k1, r_k0};
        end
    endgenerate

    assign empty1 = (r_row1[63:0] == EMPTY_MARK);
    assign empty2 = (r_row2[63:0] == EMPTY_MARK);
    assign match1 = (r_row1[63:0] == r_k0) && (r_row1[127:64] == r_k1)
                    && (!words3 || (w2_1 == r_k2));
    assign match2 = (r_row2[63:0] == r_k0) && (r_row2[127:64] == r_k1)
                    && (!words3 || (w2_2 == r_k2));
    assign lfsr_nx = lfsr_next(r_lfsr);

    // evicted occupant becomes the pending item
    always_comb begin
        if (lfsr_nx[0]) begin
            ev0  = r_row2[63:0];
            ev1  = r_row2[127:64];
            ev2  = words3 ? w2_2 : 64'd0;
            ev_v = r_row2[KW*64 +: 32];
        end else begin
            ev0  = r_row1[63:0];
            ev1  = r_row1[127:64];
            ev2  = words3 ? w2_1 : 64'd0;
            ev_v = r_row1[KW*64 +: 32];
        end
    end

    always_comb begin
        wr1     = 1'b0;
        wr2     = 1'b0;
        wd1     = ins1_row;
        wd2     = ins2_row;
        again   = 1'b0;
        eval_st = ST_NOTFOUND;
        eval_vo = '0;
        unique case (r_act)
            ACT_INSERT: begin
                priority if (empty1) begin
                    wr1 = 1'b1; eval_st = ST_OK;
                end else if (empty2) begin
                    wr2 = 1'b1; eval_st = ST_OK;
                end else if (r_kicks >= r_max_kicks) begin
                    eval_st = ST_FAILED;
                end else begin
                    again = 1'b1;
                    wr1   = !lfsr_nx[0];
                    wr2   = lfsr_nx[0];
                end
            end
            ACT_LOOKUP: begin
                priority if (match1) begin
                    eval_st = ST_OK; eval_vo = r_row1[KW*64 +: 32];
                end else if (match2) begin
                    eval_st = ST_OK; eval_vo = r_row2[KW*64 +: 32];
                end
            end
            ACT_REMOVE: begin
                wd1 = clr_row;
                wd2 = clr_row;
                wr1 = match1;
                wr2 = match2;
                if (match1 || match2) eval_st = ST_OK;
            end
            default: ;
        endcase
    end

    assign we1 = i_cmd.clr_step || (i_cmd.commit && wr1);
    assign we2 = i_cmd.clr_step || (i_cmd.commit && wr2);
    assign wa1 = i_cmd.clr_step ? r_clr : s1;
    assign wa2 = i_cmd.clr_step ? r_clr : s2;

    always_ff @(posedge i_clk) begin
        if (we1) mem1[wa1] <= i_cmd.clr_step ? clr_row : wd1;
        if (i_cmd.mem_rd) r_row1 <= mem1[s1];
    end

    always_ff @(posedge i_clk) begin
        if (we2) mem2[wa2] <= i_cmd.clr_step ? clr_row : wd2;
        if (i_cmd.mem_rd) r_row2 <= mem2[s2];
    end

    // control and config state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len   <= KEY_LEN_RESET;
            r_max_kicks <= MAX_KICKS_RESET;
            r_lfsr      <= SEED_RESET;
            r_kicks     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEY_LENGTH:  r_key_len <= i_cfg_data[1:0];
                    CFG_MAX_KICKS:   r_max_kicks <= i_cfg_data;
                    CFG_CHOICE_SEED: r_lfsr <= (i_cfg_data != '0) ? i_cfg_data
                                                                   : SEED_RESET;
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.load) r_kicks <= '0;
            if (i_cmd.commit && again) begin
                r_kicks <= r_kicks + 16'd1;
                r_lfsr  <= lfsr_nx;
            end
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= i_in_data.action;
            r_k0      <= i_in_data.key_word0;
            r_k1      <= i_in_data.key_word1;
            r_k2      <= words3 ? i_in_data.key_word2 : 64'd0;
            r_val     <= i_in_data.value;
            r_res_st  <= (i_in_data.key_word0 == EMPTY_MARK) ? ST_RESERVED : ST_NOTFOUND;
            r_res_val <= '0;
        end else if (i_cmd.commit) begin
            if (again) begin
                r_k0  <= ev0;
                r_k1  <= ev1;
                r_k2  <= ev2;
                r_val <= ev_v;
            end else begin
                r_res_st  <= eval_st;
                r_res_val <= eval_vo;
            end
        end
        if (i_cmd.out_load) begin
            r_out.status    <= r_res_st;
            r_out.value_out <= r_res_val;
        end
    end

    assign o_sts.hash_done = d1 && d2;
    assign o_sts.clr_last  = (r_clr == AW'(TABLE_ENTRIES - 1));
    assign o_sts.skip      = (r_k0 == EMPTY_MARK) ||
                             !((r_act == ACT_INSERT) || (r_act == ACT_LOOKUP) ||
                               (r_act == ACT_REMOVE));
    assign o_sts.again     = again;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    `CHM_ASSERT(a_hash_lockstep, d1 == d2, "hash units out of step")
    `CHM_ASSERT(a_kick_count, i_cmd.commit && again |=> r_kicks == $past(r_kicks) + 16'd1, "kick count slip")
    `CHM_ASSERT(a_lfsr_live, r_lfsr != 16'd0, "choice lfsr stuck at zero")
    `CHM_ASSERT_ALWAYS(a_out_reset, !i_rst_n |=> !r_out_valid, "result valid after reset")
endmodule

/* hdl/chm_ctrl.sv */
module chm_ctrl import chm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_HASH  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_EVAL  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.skip) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.hash_go = 1'b1;
                    n_state       = S_HASH;
                end
            end
            S_HASH: if (i_sts.hash_done) n_state = S_READ;
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.commit = 1'b1;
                n_state      = i_sts.again ? S_CHECK : S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end
endmodule

/* hdl/cuckoo_hash_map_unit.sv */
// Two-table cuckoo map, one word in, one result word out per operation.
// Lookup, remove and a direct insert all run check, hash, read, evaluate and output; each
// eviction adds another check, hash, read and evaluate pass. The sequential 32x32 multiply and 4-bit remainder
// steps of the hash units set the latency. A reserved key or unknown action goes from check to output.
// One operation at a time: a new word is accepted only once the previous one has reached the output register.
// Reset: synchronous active low, then a clearing pass over all TABLE_ENTRIES slots empties both tables.
module cuckoo_hash_map_unit import chm_pkg::*; #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_KEY_WORDS = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    chm_stream_if.sink       i_in,
    chm_stream_if.source     o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);
    // command/status bundle between sequencer and datapath
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: clear sweep, accept, check, hash, read both slots, evaluate,
    // loop back through check to hash on eviction, then hand the result to the output
    // register. A new word is taken while the previous result still waits.
    chm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: key registers, two hash units, two table memories
    // (key words and value in one row), eviction LFSR, kick counter,
    // config registers and the output register.
    chm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_KEY_WORDS (MAX_KEY_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );
endmodule

/* tb/tb_cuckoo_hash_map_unit.sv */
module tb_cuckoo_hash_map_unit;
    import chm_pkg::*;

    // Predictor geometry, matches the DUT defaults
    localparam int TBL   = 4096;
    localparam int NKW   = 3;
    localparam int POOLN = 16;

    typedef logic [63:0] t_key [NKW];

    // One line of the directed table: exp only trusted when chk is set
    typedef struct {
        t_in_word  w;
        bit        chk;
        t_out_word exp;
    } t_row;

    logic clk;
    logic rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    chm_stream_if #(.T(t_in_word))  in_if ();
    chm_stream_if #(.T(t_out_word)) out_if ();

    cuckoo_hash_map_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow map: [table][slot][key word], one value per slot
    logic [63:0] map_key [2][TBL][NKW];
    logic [31:0] map_val [2][TBL];
    logic [15:0] lfsr_q;
    logic [1:0]  key_len_q;
    logic [15:0] kick_limit_q;

    t_out_word result_q [$];
    bit        failed;
    int        src_idle;
    int        snk_idle;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop: covers the clearing pass, long kick chains and heavy stalls
    initial begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int words_used();
        return (key_len_q == KEY_LEN_THREE) ? 3 : 2;
    endfunction

    // Pack the key per table, multiply mod 2^128, reduce by the table modulus
    function automatic int slot_of(input int tb, input t_key k);
        logic [127:0] pk;
        logic [127:0] prod;
        logic [63:0]  ksum;
        ksum = k[0] + k[1];
        if (words_used() == 3) begin
            if (tb == 0)
                pk = {k[0], 64'd0} | ({64'd0, k[1]} << 50) | {64'd0, k[2]};
            else
                pk = ({64'd0, k[2]} << 56) | ({64'd0, k[1]} << 33) | {64'd0, ksum};
        end else begin
            pk = {k[0], k[1]};
        end
        prod = pk * ((tb == 0) ? MULT_ONE : MULT_TWO);
        return int'(prod % 128'((tb == 0) ? TBL - 5 : TBL - 2));
    endfunction

    function automatic bit slot_hit(input int tb, input int s, input t_key k);
        for (int i = 0; i < words_used(); i++)
            if (map_key[tb][s][i] != k[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void slot_put(input int tb, input int s, input t_key k,
                                     input logic [31:0] v);
        for (int i = 0; i < words_used(); i++)
            map_key[tb][s][i] = k[i];
        map_val[tb][s] = v;
    endfunction

    // Cuckoo insert; returns 0 when the kick budget runs out
    function automatic bit map_insert(input t_key key, input logic [31:0] val);
        t_key        k;
        t_key        ev;
        logic [31:0] v;
        logic [31:0] ov;
        int          kicks;
        int          s1;
        int          s2;
        int          tb;
        int          s;
        k = key;
        v = val;
        kicks = 0;
        forever begin
            s1 = slot_of(0, k);
            s2 = slot_of(1, k);
            if (map_key[0][s1][0] == EMPTY_MARK) begin
                slot_put(0, s1, k, v);
                return 1'b1;
            end
            if (map_key[1][s2][0] == EMPTY_MARK) begin
                slot_put(1, s2, k, v);
                return 1'b1;
            end
            if (kicks >= kick_limit_q)
                return 1'b0;
            kicks++;
            lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ 16'hB400) : (lfsr_q >> 1);
            tb = lfsr_q[0] ? 1 : 0;
            s  = (tb == 0) ? s1 : s2;
            ev = '{default: 64'd0};
            for (int i = 0; i < words_used(); i++)
                ev[i] = map_key[tb][s][i];
            ov = map_val[tb][s];
            slot_put(tb, s, k, v);
            k = ev;
            v = ov;
        end
    endfunction

    // Expected result word for one accepted input word; updates the shadow map
    function automatic t_out_word predict_map(input t_in_word w);
        t_out_word r;
        t_key      k;
        int        s1;
        int        s2;
        r.status    = ST_NOTFOUND;
        r.value_out = '0;
        k[0] = w.key_word0;
        k[1] = w.key_word1;
        k[2] = (words_used() == 3) ? w.key_word2 : 64'd0;
        s1 = slot_of(0, k);
        s2 = slot_of(1, k);
        if (k[0] == EMPTY_MARK) begin
            r.status = ST_RESERVED;
        end else if (w.action == ACT_INSERT) begin
            r.status = map_insert(k, w.value) ? ST_OK : ST_FAILED;
        end else if (w.action == ACT_LOOKUP) begin
            if (slot_hit(0, s1, k)) begin
                r.status = ST_OK;
                r.value_out = map_val[0][s1];
            end else if (slot_hit(1, s2, k)) begin
                r.status = ST_OK;
                r.value_out = map_val[1][s2];
            end
        end else if (w.action == ACT_REMOVE) begin
            // every matching slot is emptied, not just the first
            for (int tb = 0; tb < 2; tb++) begin
                if (slot_hit(tb, (tb == 0) ? s1 : s2, k)) begin
                    for (int i = 0; i < NKW; i++)
                        map_key[tb][(tb == 0) ? s1 : s2][i] = EMPTY_MARK;
                    map_val[tb][(tb == 0) ? s1 : s2] = '0;
                    r.status = ST_OK;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Push one word; valid stays high across back-to-back words unless a random idle gap is inserted
    task automatic send_word(input t_in_word w);
        if ($urandom_range(99) < src_idle) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        result_q.push_back(predict_map(w));
    endtask

    // Drain and let the DUT settle before a register write
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_KEY_LENGTH:  key_len_q = val[1:0];
            CFG_MAX_KICKS:   kick_limit_q = val;
            CFG_CHOICE_SEED: lfsr_q = (val == 16'd0) ? 16'd1 : val;
            default: ;
        endcase
    endtask

    // Receiver: random backpressure per idling phase
    always @(posedge clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle);
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected word, exp none got %h", $time, out_if.data);
                failed = 1'b1;
            end else begin
                t_out_word e;
                e = result_q.pop_front();
                if (out_if.data.status !== e.status) begin
                    $display("%0t: status exp %h got %h", $time, e.status,
                             out_if.data.status);
                    failed = 1'b1;
                end
                if (out_if.data.value_out !== e.value_out) begin
                    $display("%0t: value_out exp %h got %h", $time, e.value_out,
                             out_if.data.value_out);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic t_row mk_row(input logic [1:0] act, input logic [63:0] k0,
                                    input logic [63:0] k1, input logic [63:0] k2,
                                    input logic [31:0] v, input bit chk,
                                    input logic [1:0] st, input logic [31:0] vo);
        t_row r;
        r.w.action    = act;
        r.w.key_word0 = k0;
        r.w.key_word1 = k1;
        r.w.key_word2 = k2;
        r.w.value     = v;
        r.chk         = chk;
        r.exp.status  = st;
        r.exp.value_out = vo;
        return r;
    endfunction

    initial begin
        t_row        rows [$];
        t_out_word   got;
        t_in_word    w;
        t_key        pool [POOLN];
        t_key        live [$];
        logic [63:0] ka0, ka1, ka2, kb0, kb1, kb2;
        int          sel;
        int          idx;
        int          n_items;
        bit          fresh_mode;

        failed   = 1'b0;
        src_idle = 37;
        snk_idle = 79;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_KEY_LENGTH;
        cfg_data = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;

        // shadow map at reset
        for (int t = 0; t < 2; t++)
            for (int s = 0; s < TBL; s++) begin
                for (int i = 0; i < NKW; i++)
                    map_key[t][s][i] = EMPTY_MARK;
                map_val[t][s] = '0;
            end
        key_len_q    = KEY_LEN_RESET;
        kick_limit_q = MAX_KICKS_RESET;
        lfsr_q       = SEED_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero kick budget: a third copy of one key must fail outright
        cfg_write(CFG_MAX_KICKS, 16'd0);

        ka0 = 64'h0123_4567_89AB_CDEF; ka1 = 64'hFEDC_BA98_7654_3210;
        ka2 = 64'h0F0F_0F0F_F0F0_F0F0;
        kb0 = 64'h8000_0000_0000_0000; kb1 = 64'h1; kb2 = 64'hFFFF_FFFF_FFFF_FFFE;

        rows.push_back(mk_row(ACT_LOOKUP, ka0, ka1, ka2, 32'd0, 1, ST_NOTFOUND, 0));
        rows.push_back(mk_row(ACT_INSERT, ka0, ka1, ka2, 32'hFFFF_FFFF, 1, ST_OK, 0));
        rows.push_back(mk_row(ACT_LOOKUP, ka0, ka1, ka2, 32'd0, 1, ST_OK, 32'hFFFF_FFFF));
        rows.push_back(mk_row(ACT_INSERT, ka0, ka1, ka2, 32'd0, 1, ST_OK, 0));
        rows.push_back(mk_row(ACT_REMOVE, ka0, ka1, ka2, 32'd0, 1, ST_OK, 0));
        rows.push_back(mk_row(ACT_LOOKUP, ka0, ka1, ka2, 32'd0, 1, ST_NOTFOUND, 0));
        rows.push_back(mk_row(ACT_REMOVE, ka0, ka1, ka2, 32'd0, 1, ST_NOTFOUND, 0));
        // reserved first word, on every action
        rows.push_back(mk_row(ACT_INSERT, EMPTY_MARK, ka1, ka2, 32'd5, 1, ST_RESERVED, 0));
        rows.push_back(mk_row(ACT_LOOKUP, EMPTY_MARK, ka1, ka2, 32'd0, 1, ST_RESERVED, 0));
        rows.push_back(mk_row(ACT_REMOVE, EMPTY_MARK, ka1, ka2, 32'd0, 1, ST_RESERVED, 0));
        rows.push_back(mk_row(2'd3, EMPTY_MARK, ka1, ka2, 32'd0, 1, ST_RESERVED, 0));
        // unknown action
        rows.push_back(mk_row(2'd3, ka0, ka1, ka2, 32'd9, 1, ST_NOTFOUND, 0));
        // field extremes
        rows.push_back(mk_row(ACT_INSERT, '0, '0, '0, 32'd0, 1, ST_OK, 0));
        rows.push_back(mk_row(ACT_INSERT, '1, '1, '1, 32'd1, 1, ST_OK, 0));
        rows.push_back(mk_row(ACT_LOOKUP, '0, '0, '0, 32'd0, 1, ST_OK, 0));
        rows.push_back(mk_row(ACT_LOOKUP, '1, '1, '1, 32'd0, 1, ST_OK, 32'd1));
        rows.push_back(mk_row(ACT_LOOKUP, '1, '1, '0, 32'd0, 1, ST_NOTFOUND, 0));
        // just past the empty marker is a normal key
        rows.push_back(mk_row(ACT_INSERT, kb0, kb1, kb2, 32'h8000_0000, 0, ST_OK, 0));
        rows.push_back(mk_row(ACT_LOOKUP, kb0, kb1, kb2, 32'd0, 0, ST_OK, 0));
        // duplicate fills both tables, third copy has no room
        rows.push_back(mk_row(ACT_INSERT, kb0, kb1, kb2, 32'h1234_5678, 0, ST_OK, 0));
        rows.push_back(mk_row(ACT_INSERT, kb0, kb1, kb2, 32'd7, 1, ST_FAILED, 0));
        rows.push_back(mk_row(ACT_REMOVE, kb0, kb1, kb2, 32'd0, 1, ST_OK, 0));
        rows.push_back(mk_row(ACT_LOOKUP, kb0, kb1, kb2, 32'd0, 1, ST_NOTFOUND, 0));

        foreach (rows[r]) begin
            if (rows[r].chk) begin
                got = predict_map(rows[r].w);
                // undo nothing: directed rows are consistent with the shadow map
                if (got != rows[r].exp) begin
                    $display("%0t: table row %0d exp %h got %h", $time, r,
                             rows[r].exp, got);
                    failed = 1'b1;
                end
                // replay through the real path: restore is not needed since
                // predict_map already ran, so push directly
                if ($urandom_range(99) < src_idle) begin
                    in_if.valid <= 1'b0;
                    repeat ($urandom_range(4, 1)) @(posedge clk);
                end
                in_if.valid <= 1'b1;
                in_if.data  <= rows[r].w;
                @(posedge clk);
                while (!in_if.ready) @(posedge clk);
                result_q.push_back(rows[r].exp);
            end else begin
                send_word(rows[r].w);
            end
        end

        n_items = 0;
        // four random phases, register settings per phase
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    cfg_write(CFG_KEY_LENGTH, 16'd3);
                    cfg_write(CFG_MAX_KICKS, 16'hFFFF);
                    cfg_write(CFG_CHOICE_SEED, 16'hFFFF);
                end
                1: begin
                    cfg_write(CFG_KEY_LENGTH, 16'd2);
                    cfg_write(CFG_MAX_KICKS, 16'd7);
                    cfg_write(CFG_CHOICE_SEED, 16'd1);
                end
                2: begin
                    // below two words still means two
                    cfg_write(CFG_KEY_LENGTH, 16'd1);
                    cfg_write(CFG_MAX_KICKS, 16'd1);
                    cfg_write(CFG_CHOICE_SEED, 16'($urandom_range(65535, 1)));
                end
                default: begin
                    cfg_write(CFG_KEY_LENGTH, 16'd3);
                    cfg_write(CFG_MAX_KICKS, 16'd20);
                    cfg_write(CFG_CHOICE_SEED, 16'($urandom_range(65535, 1)));
                end
            endcase
            // huge kick budget: only distinct fresh keys, so chains stay short
            fresh_mode = (ph == 0);
            live.delete();
            for (int p = 0; p < POOLN; p++)
                pool[p] = '{rand64(), rand64(), rand64()};

            for (int it = 0; it < 375; it++) begin
                if (n_items < 500) begin
                    src_idle = 37; snk_idle = 79;
                end else if (n_items < 1000) begin
                    src_idle = 79; snk_idle = 37;
                end else begin
                    src_idle = 0; snk_idle = 0;
                end
                w.key_word0 = rand64();
                w.key_word1 = rand64();
                w.key_word2 = rand64();
                w.value     = $urandom;
                sel = $urandom_range(99);
                if (sel < 4) begin
                    w.action    = 2'($urandom_range(3));
                    w.key_word0 = EMPTY_MARK;
                end else if (sel < 7) begin
                    w.action = 2'd3;
                end else if (fresh_mode) begin
                    if (sel < 52 || live.size() == 0) begin
                        w.action = ACT_INSERT;
                        live.push_back('{w.key_word0, w.key_word1, w.key_word2});
                    end else if (sel < 90) begin
                        idx = $urandom_range(live.size() - 1);
                        w.key_word0 = live[idx][0];
                        w.key_word1 = live[idx][1];
                        w.key_word2 = live[idx][2];
                        if (sel < 75) begin
                            w.action = ACT_LOOKUP;
                        end else begin
                            w.action = ACT_REMOVE;
                            live.delete(idx);
                        end
                    end else begin
                        w.action = (sel < 95) ? ACT_LOOKUP : ACT_REMOVE;
                    end
                end else begin
                    // small pool: hits, duplicates, evictions and kick-limit drops
                    idx = $urandom_range(POOLN - 1);
                    w.key_word0 = pool[idx][0];
                    w.key_word1 = pool[idx][1];
                    w.key_word2 = pool[idx][2];
                    if (sel < 45)
                        w.action = ACT_INSERT;
                    else if (sel < 75)
                        w.action = ACT_LOOKUP;
                    else
                        w.action = ACT_REMOVE;
                end
                send_word(w);
                n_items++;
            end
        end

        in_if.valid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        if (!failed && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/chm_pkg.sv
hdl/chm_stream_if.sv
hdl/chm_hash.sv
hdl/chm_datapath.sv
hdl/chm_ctrl.sv
hdl/cuckoo_hash_map_unit.sv
tb/tb_cuckoo_hash_map_unit.sv
